// ----- rtl/kidt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kidt_pkg
// Shared constants, codes and controller/datapath types for the key id table.
// ----------------------------------------------------------------------------
package kidt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int ID_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int FUNC_W      = 3;
  localparam int IN_KEY_W    = 32;
  localparam int OUT_KEY_W   = 32;
  localparam int STATUS_W    = 2;

  localparam logic [FUNC_W-1:0] FN_GET_OR_ASSIGN = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FIND          = 3'd1;
  localparam logic [FUNC_W-1:0] FN_READ_BY_ID    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE_BY_KEY = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE_BY_ID  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR         = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_FIN,
    S_SHRINK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic read;
    logic fin;
    logic shrink;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic need_shrink;
    logic shrink_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/key_id_table_first_free.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// key_id_table_first_free
// Key to id table with lowest-free-slot assignment over stream ports.
// ----------------------------------------------------------------------------
// get_or_assign, find and remove_by_key run a one-slot-per-cycle scan of the key
//   ram over the extent, stopping at a match, before the finish and the result
// read_by_id reads the key ram before finishing; remove_by_id, clear and others
// finish directly; a removal that hits then trims trailing empty slots off extent
// one word in flight: the next word is taken after the result is taken
// reset clears all valid bits and the extent; keys are kept
module key_id_table_first_free import kidt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // key[31:0], slot_id[37:32], zero pad
  input  wire logic [2:0]  s_tuser,  // func[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,  // result_id[5:0], result_key[37:6],
                                     // allocated_count[44:38], zero pad
  output logic      [1:0]  m_tuser   // status[1:0]
);

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [ID_W-1:0]      result_id;
  logic [OUT_KEY_W-1:0] result_key;
  logic [STATUS_W-1:0]  status;
  logic [CNT_W-1:0]     allocated_count;

  kidt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_func   (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  kidt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_func         (s_tuser),
    .in_key          (s_tdata[31:0]),
    .in_slot_id      (s_tdata[37:32]),
    .cmd             (cmd),
    .stat            (stat),
    .result_id       (result_id),
    .result_key      (result_key),
    .status          (status),
    .allocated_count (allocated_count)
  );

  assign m_tdata = {3'b000, allocated_count, result_key, result_id};
  assign m_tuser = status;

endmodule
`default_nettype wire

// ----- rtl/kidt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kidt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kidt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/kidt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kidt_ctrl
// Operation sequencer: accept, scan or read, finish, trim extent, deliver.
// ----------------------------------------------------------------------------
module kidt_ctrl import kidt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [FUNC_W-1:0] in_func,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dp_cmd_t                cmd,
  input  wire dp_stat_t          stat
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func) inside
            FN_GET_OR_ASSIGN, FN_FIND, FN_REMOVE_BY_KEY: state_next = S_SCAN;
            FN_READ_BY_ID:                               state_next = S_READ;
            default:                                     state_next = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_FIN;
        end
      end
      S_READ: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = stat.need_shrink ? S_SHRINK : S_OUT;
      end
      S_SHRINK: begin
        if (stat.shrink_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_OUT);
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.read   = (state == S_READ);
    cmd.fin    = (state == S_FIN);
    cmd.shrink = (state == S_SHRINK);
  end

endmodule
`default_nettype wire

// ----- rtl/kidt_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kidt_dp
// Table datapath: key memory, slot valid bits, extent, scan pipe and results.
// ----------------------------------------------------------------------------
module kidt_dp import kidt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [IN_KEY_W-1:0]  in_key,
  input  wire logic [ID_W-1:0]      in_slot_id,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  output logic      [ID_W-1:0]      result_id,
  output logic      [OUT_KEY_W-1:0] result_key,
  output logic      [STATUS_W-1:0]  status,
  output logic      [CNT_W-1:0]     allocated_count
);

  logic [FUNC_W-1:0]    func_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [ID_W-1:0]      sid_q;

  logic [TABLE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]       extent;
  logic [CNT_W-1:0]       ext_dec;

  logic [CNT_W-1:0] scan_idx;
  logic             issue;
  logic             pipe_vld;
  logic [ID_W-1:0]  pipe_idx;
  logic             match;
  logic             hit_found;
  logic [ID_W-1:0]  hit_idx;
  logic             free_found;
  logic [ID_W-1:0]  free_idx;

  logic [KEY_WIDTH-1:0] rd_data;
  logic [ID_W-1:0]      rd_addr;
  logic                 wr_en;
  logic [ID_W-1:0]      wr_addr;

  logic                 sid_ok;
  logic                 set_en;
  logic                 clr_en;
  logic [ID_W-1:0]      clr_idx;
  logic                 ext_inc;
  logic                 clear_all;
  logic                 need_shrink;
  logic                 shrink_done;
  logic [ID_W-1:0]      res_id_next;
  logic [OUT_KEY_W-1:0] res_key_next;
  logic [STATUS_W-1:0]  res_status_next;

  kidt_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key_q),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_addr     = cmd.read ? sid_q : scan_idx[ID_W-1:0];
  assign issue       = scan_idx < extent;
  assign match       = pipe_vld && valid[pipe_idx] && (rd_data == key_q);
  assign ext_dec     = extent - 1'b1;
  assign shrink_done = (extent == '0) || valid[ext_dec[ID_W-1:0]];
  assign sid_ok      = (CNT_W'(sid_q) < extent) && valid[sid_q];

  assign stat.scan_done   = match || (!pipe_vld && !issue);
  assign stat.need_shrink = need_shrink;
  assign stat.shrink_done = shrink_done;

  // finishing step of each operation
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = free_idx;
    set_en          = 1'b0;
    clr_en          = 1'b0;
    clr_idx         = hit_idx;
    ext_inc         = 1'b0;
    clear_all       = 1'b0;
    need_shrink     = 1'b0;
    res_id_next     = '0;
    res_key_next    = '0;
    res_status_next = ST_OK;
    case (func_q)
      FN_GET_OR_ASSIGN: begin
        if (hit_found) begin
          res_id_next = hit_idx;
        end else if (free_found) begin
          wr_en       = cmd.fin;
          set_en      = cmd.fin;
          res_id_next = free_idx;
        end else if (extent < CNT_W'(TABLE_DEPTH)) begin
          wr_en       = cmd.fin;
          wr_addr     = extent[ID_W-1:0];
          set_en      = cmd.fin;
          ext_inc     = cmd.fin;
          res_id_next = extent[ID_W-1:0];
        end else begin
          res_status_next = ST_FULL;
        end
      end
      FN_FIND: begin
        if (hit_found) begin
          res_id_next = hit_idx;
        end else begin
          res_status_next = ST_NOT_FOUND;
        end
      end
      FN_READ_BY_ID: begin
        if (sid_ok) begin
          res_id_next  = sid_q;
          res_key_next = OUT_KEY_W'(rd_data);
        end else begin
          res_status_next = ST_NOT_FOUND;
        end
      end
      FN_REMOVE_BY_KEY: begin
        if (hit_found) begin
          clr_en      = cmd.fin;
          need_shrink = 1'b1;
          res_id_next = hit_idx;
        end else begin
          res_status_next = ST_NOT_FOUND;
        end
      end
      FN_REMOVE_BY_ID: begin
        if (sid_ok) begin
          clr_en      = cmd.fin;
          clr_idx     = sid_q;
          need_shrink = 1'b1;
          res_id_next = sid_q;
        end else begin
          res_status_next = ST_NOT_FOUND;
        end
      end
      FN_CLEAR: begin
        clear_all = cmd.fin;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= in_func;
      key_q  <= KEY_WIDTH'(in_key);
      sid_q  <= in_slot_id;
    end
    if (cmd.fin) begin
      result_id  <= res_id_next;
      result_key <= res_key_next;
    end
    if (cmd.scan && issue) begin
      pipe_idx <= scan_idx[ID_W-1:0];
    end
    if (cmd.scan && match) begin
      hit_idx <= pipe_idx;
    end
    if (cmd.scan && pipe_vld && !valid[pipe_idx] && !free_found) begin
      free_idx <= pipe_idx;
    end
  end

  // scan pipe control
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      pipe_vld   <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      status     <= ST_OK;
    end else begin
      if (cmd.load) begin
        scan_idx   <= '0;
        pipe_vld   <= 1'b0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.scan) begin
        pipe_vld <= issue;
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (match) begin
          hit_found <= 1'b1;
        end
        if (pipe_vld && !valid[pipe_idx]) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.fin) begin
        status <= res_status_next;
      end
    end
  end

  // slot valid bits and extent
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      extent <= '0;
    end else if (clear_all) begin
      valid  <= '0;
      extent <= '0;
    end else begin
      if (set_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid[clr_idx] <= 1'b0;
      end
      if (ext_inc) begin
        extent <= extent + 1'b1;
      end else if (cmd.shrink && !shrink_done) begin
        extent <= ext_dec;
      end
    end
  end

  assign allocated_count = extent;

endmodule
`default_nettype wire
